/* hdl/q2e_pkg.sv */
// q2e_pkg: request and result types, pipeline record types and the CORDIC
// arctangent table for quaternion_to_euler_bins. No dependencies.
`default_nettype none
package q2e_pkg;

   localparam int NSQ = 29;   // root steps, one result bit each
   localparam int NCR = 28;   // CORDIC vectoring steps

   localparam logic [29:0] ATAN_TAB [0:NCR-1] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
      30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
      30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
      30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
      30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
      30'h00000014, 30'h0000000A, 30'h00000005
   };

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_type;

   typedef struct packed {
      logic [4:0] roll_bin;
      logic [4:0] pitch_bin;
      logic [4:0] yaw_bin;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] wx, yz, xx, yy, wz, xy, zz, wy, zx;
   } prod_type;

   typedef struct packed {
      logic signed [33:0] rn, rd, yn, yd;
      logic signed [29:0] s;
      logic [57:0]        v;
      logic [57:0]        res;
   } pl_type;

   typedef struct packed {
      logic signed [39:0] x, y;
      logic signed [33:0] z;
      logic               zr;
   } cr_type;

endpackage
`default_nettype wire

/* hdl/quaternion_to_euler_bins.sv */
// quaternion_to_euler_bins: quaternion in, roll/pitch/yaw bins out.
// A fully pipelined datapath; depends on q2e_pkg.
//
// Takes one quaternion per cycle while the result is not stalled. Most of
// its register stages are the 29-step square root for the pitch cosine
// followed by the 28-step CORDIC, one step per stage. A stalled result holds
// the whole pipeline; nothing is dropped or repeated. No internal state
// survives between requests.
`default_nettype none
module quaternion_to_euler_bins
   import q2e_pkg::*;
#(
   parameter int BINS = 18
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int NST = 3 + NSQ + 1 + NCR + 2;

   logic [NST-1:0] vld_ff, vld_in;
   logic           en;

   prod_type prod_ff, prod_in;
   pl_type   pre_ff, pre_in;
   pl_type   sq_ff, sq_in;
   pl_type   sqr_ff [0:NSQ-1];
   pl_type   sqr_in [0:NSQ-1];
   cr_type   cr_ff  [0:NCR][0:2];
   cr_type   cr_in  [0:NCR][0:2];
   logic [40:0] mul_ff [0:2];
   logic [40:0] mul_in [0:2];
   rsp_type  out_ff, out_in;

   assign en        = !(vld_ff[NST-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = out_ff;
   assign vld_in    = {vld_ff[NST-2:0], req_valid};

   // products
   always_comb begin
      prod_in.wx = 32'(req_data.quat_w) * 32'(req_data.quat_x);
      prod_in.yz = 32'(req_data.quat_y) * 32'(req_data.quat_z);
      prod_in.xx = 32'(req_data.quat_x) * 32'(req_data.quat_x);
      prod_in.yy = 32'(req_data.quat_y) * 32'(req_data.quat_y);
      prod_in.wz = 32'(req_data.quat_w) * 32'(req_data.quat_z);
      prod_in.xy = 32'(req_data.quat_x) * 32'(req_data.quat_y);
      prod_in.zz = 32'(req_data.quat_z) * 32'(req_data.quat_z);
      prod_in.wy = 32'(req_data.quat_w) * 32'(req_data.quat_y);
      prod_in.zx = 32'(req_data.quat_z) * 32'(req_data.quat_x);
   end

   // sums and the clamp of the sine
   always_comb begin
      logic signed [33:0] sr;
      pre_in    = '0;
      pre_in.rn = (34'(prod_ff.wx) + 34'(prod_ff.yz)) <<< 1;
      pre_in.rd = 34'sd268435456 - ((34'(prod_ff.xx) + 34'(prod_ff.yy)) <<< 1);
      pre_in.yn = (34'(prod_ff.wz) + 34'(prod_ff.xy)) <<< 1;
      pre_in.yd = 34'sd268435456 - ((34'(prod_ff.yy) + 34'(prod_ff.zz)) <<< 1);
      sr        = (34'(prod_ff.wy) - 34'(prod_ff.zx)) <<< 1;
      if (sr > 34'sd268435456)       pre_in.s = 30'sd268435456;
      else if (sr < -34'sd268435456) pre_in.s = -30'sd268435456;
      else                           pre_in.s = sr[29:0];
   end

   // radicand 2^56 - s*s
   always_comb begin
      logic [28:0] sm;
      logic [57:0] ss;
      sq_in     = pre_ff;
      sm        = pre_ff.s[29] ? 29'(-pre_ff.s) : 29'(pre_ff.s);
      ss        = 58'(sm) * 58'(sm);
      sq_in.v   = (58'd1 << 56) - ss;
      sq_in.res = '0;
   end

   // digit-by-digit square root, one step per stage
   always_comb begin
      pl_type      src;
      logic [57:0] one, t;
      for (int k = 0; k < NSQ; k++) begin
         src = (k == 0) ? sq_ff : sqr_ff[k-1];
         one = 58'd1 << (56 - 2 * k);
         t   = src.res + one;
         sqr_in[k] = src;
         if (src.v >= t) begin
            sqr_in[k].v   = src.v - t;
            sqr_in[k].res = (src.res >> 1) + one;
         end else begin
            sqr_in[k].res = src.res >> 1;
         end
      end
   end

   // quadrant fold into the right half plane, then CORDIC steps
   always_comb begin
      logic signed [39:0] vx [0:2];
      logic signed [39:0] vy [0:2];
      logic signed [39:0] dx, dy;
      vy[0] = 40'(sqr_ff[NSQ-1].rn);
      vx[0] = 40'(sqr_ff[NSQ-1].rd);
      vy[1] = 40'(sqr_ff[NSQ-1].s);
      vx[1] = 40'(sqr_ff[NSQ-1].res[28:0]);
      vy[2] = 40'(sqr_ff[NSQ-1].yn);
      vx[2] = 40'(sqr_ff[NSQ-1].yd);
      for (int l = 0; l < 3; l++) begin
         cr_in[0][l].zr = (vx[l] == '0) && (vy[l] == '0);
         cr_in[0][l].x  = vx[l];
         cr_in[0][l].y  = vy[l];
         cr_in[0][l].z  = '0;
         if (vx[l] < 0) begin
            if (vy[l] >= 0) begin
               cr_in[0][l].x = vy[l];
               cr_in[0][l].y = -vx[l];
               cr_in[0][l].z = 34'sd1073741824;
            end else begin
               cr_in[0][l].x = -vy[l];
               cr_in[0][l].y = vx[l];
               cr_in[0][l].z = -34'sd1073741824;
            end
         end
      end
      for (int i = 0; i < NCR; i++) begin
         for (int l = 0; l < 3; l++) begin
            dx = cr_ff[i][l].y >>> i;
            dy = cr_ff[i][l].x >>> i;
            cr_in[i+1][l] = cr_ff[i][l];
            if (cr_ff[i][l].y >= 0) begin
               cr_in[i+1][l].x = cr_ff[i][l].x + dx;
               cr_in[i+1][l].y = cr_ff[i][l].y - dy;
               cr_in[i+1][l].z = cr_ff[i][l].z + 34'(ATAN_TAB[i]);
            end else begin
               cr_in[i+1][l].x = cr_ff[i][l].x - dx;
               cr_in[i+1][l].y = cr_ff[i][l].y + dy;
               cr_in[i+1][l].z = cr_ff[i][l].z - 34'(ATAN_TAB[i]);
            end
         end
      end
   end

   // offset and scale
   always_comb begin
      logic signed [33:0] a, half;
      logic [32:0]        u;
      for (int l = 0; l < 3; l++) begin
         half = (l == 1) ? 34'sd1073741824 : 34'sd2147483648;
         a    = cr_ff[NCR][l].zr ? 34'sd0 : cr_ff[NCR][l].z;
         if (a > half)  a = half;
         if (a < -half) a = -half;
         u = 33'(a + half);
         mul_in[l] = 41'(u) * 41'(BINS);
      end
   end

   // truncate and saturate
   always_comb begin
      logic [9:0] b [0:2];
      b[0] = mul_ff[0][40:31] >> 1;
      b[1] = mul_ff[1][40:31];
      b[2] = mul_ff[2][40:31] >> 1;
      for (int l = 0; l < 3; l++) begin
         if (b[l] > 10'(BINS)) b[l] = 10'(BINS);
      end
      out_in.roll_bin  = b[0][4:0];
      out_in.pitch_bin = b[1][4:0];
      out_in.yaw_bin   = b[2][4:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         prod_ff <= prod_in;
         pre_ff  <= pre_in;
         sq_ff   <= sq_in;
         for (int k = 0; k < NSQ; k++) sqr_ff[k] <= sqr_in[k];
         for (int i = 0; i <= NCR; i++) begin
            for (int l = 0; l < 3; l++) cr_ff[i][l] <= cr_in[i][l];
         end
         for (int l = 0; l < 3; l++) mul_ff[l] <= mul_in[l];
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire
